// ===== sv/gflt_pkg.sv =====
// Shared types and constants for the finish line lap timer.
`default_nettype none

package gflt_pkg;

	// Line geometry selected by the mode register. The unused code behaves as horizontal.
	localparam logic [1:0] MODE_HORIZ  = 2'd0;
	localparam logic [1:0] MODE_SLOPED = 2'd1;
	localparam logic [1:0] MODE_VERT   = 2'd2;

	// Register indexes; register i sits at byte address 8*i.
	localparam logic [2:0] REG_LON_A  = 3'd0;
	localparam logic [2:0] REG_LAT_A  = 3'd1;
	localparam logic [2:0] REG_LON_B  = 3'd2;
	localparam logic [2:0] REG_LAT_B  = 3'd3;
	localparam logic [2:0] REG_MODE   = 3'd4;
	localparam logic [2:0] REG_SLOPE  = 3'd5;
	localparam logic [2:0] REG_OFFSET = 3'd6;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Operation codes of an input transaction.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic [26:0] LAP_TIME_MAX  = 27'd86399999;
	localparam logic [15:0] LAP_COUNT_MAX = 16'hFFFF;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic signed [31:0] lon_a;
		logic signed [30:0] lat_a;
		logic signed [31:0] lon_b;
		logic signed [30:0] lat_b;
		logic [1:0]         mode;
		logic signed [31:0] slope;
		logic signed [47:0] offset;
	} line_cfg_t;

	// One classified transaction handed from the front end to the lap engine.
	typedef struct packed {
		logic        op;
		logic        crossed;
		logic [31:0] time_ms;
	} lap_item_t;

	typedef struct packed {
		logic        crossed;
		logic        lap_started;
		logic        lap_done;
		logic [15:0] lap_count;
		logic [26:0] lap_time_ms;
		logic [26:0] best_lap_ms;
		logic        new_best;
	} lap_result_t;

endpackage

`default_nettype wire

// ===== sv/gflt_front.sv =====
// Front end: accepts samples, computes the line offset and flags crossings.
`default_nettype none

module gflt_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  gflt_pkg::line_cfg_t      cfg,
	input  wire                      sample_valid,
	output logic                     sample_stall,
	input  wire                      operation,
	input  wire signed [30:0]        latitude,
	input  wire signed [31:0]        longitude,
	input  wire [31:0]               time_ms,
	output logic                     push,
	output gflt_pkg::lap_item_t      push_item,
	input  wire                      full
);
	import gflt_pkg::*;

	logic signed [63:0] prod;
	logic               span_in;
	logic               accept;
	logic               en_s1;
	logic               en_s2;

	logic               valid_s1;
	logic               op_s1;
	logic signed [30:0] lat_s1;
	logic signed [31:0] lon_s1;
	logic [31:0]        time_s1;
	logic signed [63:0] prod_s1;
	logic               span_s1;

	logic signed [47:0] floor_s1;
	logic signed [49:0] cur;

	logic               valid_s2;
	logic               op_s2;
	logic [31:0]        time_s2;
	logic               span_s2;
	logic               neg_s2;
	logic               zero_s2;

	logic               prev_neg_q;
	logic               prev_zero_q;
	logic               sign_ok;

	// Full 64-bit product of two signed 32-bit operands.
	assign prod = cfg.slope * longitude;

	// Bounds are inclusive and the endpoints may come in either order.
	assign span_in = (longitude <= cfg.lon_b && longitude >= cfg.lon_a) ||
	                 (longitude <= cfg.lon_a && longitude >= cfg.lon_b) ||
	                 (latitude <= cfg.lat_b && latitude >= cfg.lat_a) ||
	                 (latitude <= cfg.lat_a && latitude >= cfg.lat_b);

	assign push         = valid_s2 && !full;
	assign en_s2        = !valid_s2 || push;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;
	assign accept       = sample_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			lat_s1  <= latitude;
			lon_s1  <= longitude;
			time_s1 <= time_ms;
			prod_s1 <= prod;
			span_s1 <= span_in;
		end
	end

	// An arithmetic shift of the product is the floor of the Q16.16 result.
	assign floor_s1 = prod_s1[63:16];

	always_comb begin
		case (cfg.mode)
			MODE_SLOPED: cur = 50'(lat_s1) - (50'(floor_s1) + 50'(cfg.offset));
			MODE_VERT:   cur = 50'(lon_s1) - 50'(cfg.lon_a);
			MODE_HORIZ:  cur = 50'(lat_s1) - 50'(cfg.lat_a);
			default:     cur = 50'(lat_s1) - 50'(cfg.lat_a);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			op_s2   <= op_s1;
			time_s2 <= time_s1;
			span_s2 <= span_s1;
			neg_s2  <= cur[49];
			zero_s2 <= (cur == 50'sd0);
		end
	end

	// Only the sign class of the previous offset matters to the crossing test.
	assign sign_ok = prev_zero_q || zero_s2 ||
	                 (prev_neg_q && !neg_s2) ||
	                 (!prev_neg_q && neg_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_neg_q  <= 1'b0;
			prev_zero_q <= 1'b1;
		end else if (push && op_s2 == OP_SAMPLE) begin
			prev_neg_q  <= neg_s2;
			prev_zero_q <= zero_s2;
		end
	end

	assign push_item.op      = op_s2;
	assign push_item.crossed = (op_s2 == OP_SAMPLE) && sign_ok && span_s2;
	assign push_item.time_ms = time_s2;

endmodule

`default_nettype wire

// ===== sv/gflt_fifo.sv =====
// Short queue between the front end and the lap engine.
`default_nettype none

module gflt_fifo #(
	parameter int DEPTH = gflt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  gflt_pkg::lap_item_t  push_item,
	output logic                 full,
	input  wire                  pop,
	output gflt_pkg::lap_item_t  head,
	output logic                 empty
);
	import gflt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	lap_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== sv/gflt_back.sv =====
// Lap engine: keeps lap state and holds the result register.
`default_nettype none

module gflt_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    empty,
	input  gflt_pkg::lap_item_t    head,
	output logic                   pop,
	output logic                   result_valid,
	input  wire                    result_stall,
	output gflt_pkg::lap_result_t  result
);
	import gflt_pkg::*;

	logic        count_bump;
	logic [15:0] count_q;
	logic        active_q;
	logic [31:0] start_q;
	logic [26:0] best_q;
	logic [26:0] last_q;

	logic        result_valid_q;
	lap_result_t result_q;

	logic [31:0] elapsed;
	logic [26:0] lap_sat;
	logic        take_best;
	lap_result_t nxt;

	assign pop = !empty && (!result_valid_q || !result_stall);

	assign elapsed    = head.time_ms - start_q;
	assign lap_sat    = (elapsed > {5'b0, LAP_TIME_MAX}) ? LAP_TIME_MAX : elapsed[26:0];
	assign take_best  = (count_q == 16'd1) || (lap_sat < best_q);
	assign count_bump = (count_q != LAP_COUNT_MAX);

	always_comb begin
		nxt.crossed     = 1'b0;
		nxt.lap_started = 1'b0;
		nxt.lap_done    = 1'b0;
		nxt.new_best    = 1'b0;
		nxt.lap_count   = count_q;
		nxt.lap_time_ms = last_q;
		nxt.best_lap_ms = best_q;
		if (head.op == OP_CLEAR) begin
			nxt.lap_count   = '0;
			nxt.best_lap_ms = '0;
		end else if (head.crossed) begin
			nxt.crossed = 1'b1;
			if (active_q) begin
				nxt.lap_done    = 1'b1;
				nxt.lap_time_ms = lap_sat;
				if (take_best) begin
					nxt.best_lap_ms = lap_sat;
					nxt.new_best    = 1'b1;
				end
			end else begin
				nxt.lap_started = 1'b1;
			end
			if (count_bump) begin
				nxt.lap_count = count_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			active_q       <= 1'b0;
			start_q        <= '0;
			best_q         <= '0;
			last_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_valid_q || !result_stall) begin
				result_valid_q <= !empty;
			end
			if (pop) begin
				count_q <= nxt.lap_count;
				best_q  <= nxt.best_lap_ms;
				last_q  <= nxt.lap_time_ms;
				if (head.op == OP_CLEAR) begin
					active_q <= 1'b0;
				end else if (head.crossed) begin
					active_q <= 1'b1;
					start_q  <= head.time_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_done_is_crossing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.lap_done || result_q.lap_started) |-> result_q.crossed)
		else $error("lap event without a crossing");

	a_start_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.lap_done && result_q.lap_started))
		else $error("lap both started and completed");

	a_best_needs_lap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.new_best |->
			result_q.lap_done && result_q.best_lap_ms == result_q.lap_time_ms)
		else $error("new best without a matching completed lap");

	a_best_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= LAP_TIME_MAX && last_q <= LAP_TIME_MAX)
		else $error("lap time beyond saturation limit");

endmodule

`default_nettype wire

// ===== sv/gps_finish_line_lap_timer_unit.sv =====
// Top level of the finish line lap timer: configuration registers and the front and back parts.
//
//  Channel   Handshake                        Payload
//  --------  -------------------------------  -------------------------------------------
//  sample    sample_valid / sample_stall      operation, latitude, longitude, time_ms
//  result    result_valid / result_stall      crossed, lap_started, lap_done, lap_count,
//                                             lap_time_ms, best_lap_ms, new_best
//  config    psel, penable, pwrite, pready    paddr (8-byte aligned), pwdata, prdata
//
// The block takes one sample transaction per clock while sample_stall is low and gives one
// result transaction per sample. A sample passes the slope multiplier register, the offset
// and sign register, the queue and the result register, in that order. The reset is
// asynchronous and clears all lap state and the configuration registers; no clearing pass
// follows it. A stalled result only stops the lap engine, and samples are still taken until
// the queue and the two front registers are full.
`default_nettype none

module gps_finish_line_lap_timer_unit #(
	parameter int QUEUE_DEPTH = gflt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [gflt_pkg::ADDR_W-1:0]   paddr,
	input  wire [gflt_pkg::DATA_W-1:0]   pwdata,
	output logic [gflt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,

	input  wire                          sample_valid,
	output logic                         sample_stall,
	input  wire                          operation,
	input  wire signed [30:0]            latitude,
	input  wire signed [31:0]            longitude,
	input  wire [31:0]                   time_ms,

	output logic                         result_valid,
	input  wire                          result_stall,
	output logic                         crossed,
	output logic                         lap_started,
	output logic                         lap_done,
	output logic [15:0]                  lap_count,
	output logic [26:0]                  lap_time_ms,
	output logic [26:0]                  best_lap_ms,
	output logic                         new_best
);
	import gflt_pkg::*;

	line_cfg_t   cfg_q;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	logic        push;
	lap_item_t   push_item;
	logic        full;
	logic        pop;
	lap_item_t   head;
	logic        empty;
	lap_result_t result;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:3];

	// The user must write registers only while the block is idle, so a write never meets a
	// sample in flight; the block does not enforce this. Writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LON_A:  cfg_q.lon_a  <= pwdata[31:0];
				REG_LAT_A:  cfg_q.lat_a  <= pwdata[30:0];
				REG_LON_B:  cfg_q.lon_b  <= pwdata[31:0];
				REG_LAT_B:  cfg_q.lat_b  <= pwdata[30:0];
				REG_MODE:   cfg_q.mode   <= pwdata[1:0];
				REG_SLOPE:  cfg_q.slope  <= pwdata[31:0];
				REG_OFFSET: cfg_q.offset <= pwdata[47:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Signed registers read back sign-extended to the full data width.
	always_comb begin
		case (reg_idx)
			REG_LON_A:  prdata = DATA_W'(cfg_q.lon_a);
			REG_LAT_A:  prdata = DATA_W'(cfg_q.lat_a);
			REG_LON_B:  prdata = DATA_W'(cfg_q.lon_b);
			REG_LAT_B:  prdata = DATA_W'(cfg_q.lat_b);
			REG_MODE:   prdata = {{(DATA_W-2){1'b0}}, cfg_q.mode};
			REG_SLOPE:  prdata = DATA_W'(cfg_q.slope);
			REG_OFFSET: prdata = DATA_W'(cfg_q.offset);
			default:    prdata = '0;
		endcase
	end

	// The front end classifies each sample as a crossing or not; it owns the sign
	// history of the line offset.
	gflt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.operation    (operation),
		.latitude     (latitude),
		.longitude    (longitude),
		.time_ms      (time_ms),
		.push         (push),
		.push_item    (push_item),
		.full         (full)
	);

	gflt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// The lap engine owns timing, the lap count and the best lap.
	gflt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign crossed     = result.crossed;
	assign lap_started = result.lap_started;
	assign lap_done    = result.lap_done;
	assign lap_count   = result.lap_count;
	assign lap_time_ms = result.lap_time_ms;
	assign best_lap_ms = result.best_lap_ms;
	assign new_best    = result.new_best;

endmodule

`default_nettype wire
